FILE: src/sdfe_pkg.sv
// Package for the station display frame emitter: payload structs, codes and
// the sequencer microcode ROM. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdfe_pkg;

  localparam int UPC_W = 6;

  // request codes
  localparam logic REQ_STATUS = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // run state codes
  localparam logic [2:0] RUN_OPEN     = 3'd0;
  localparam logic [2:0] RUN_CLOSE    = 3'd1;
  localparam logic [2:0] RUN_PRE_DOOR = 3'd3;

  // config register select (paddr[2])
  localparam logic CFG_IDLE_GAP = 1'b0;
  localparam logic CFG_REPEAT   = 1'b1;

  // microcode ops
  localparam logic [1:0] OP_EMIT   = 2'd0;
  localparam logic [1:0] OP_BRANCH = 2'd1;
  localparam logic [1:0] OP_HALT   = 2'd2;

  // byte sources
  localparam logic [2:0] SRC_CONST = 3'd0;
  localparam logic [2:0] SRC_START = 3'd1;
  localparam logic [2:0] SRC_END   = 3'd2;
  localparam logic [2:0] SRC_NEXT  = 3'd3;
  localparam logic [2:0] SRC_B6    = 3'd4;
  localparam logic [2:0] SRC_B7    = 3'd5;
  localparam logic [2:0] SRC_SUM   = 3'd6;

  localparam logic [UPC_W-1:0] CLEAR_ENTRY = 6'd16;
  localparam logic [UPC_W-1:0] CLEAR_LAST  = 6'd33;

  localparam logic [7:0] CLEAR_FRAME [18] = '{
    8'hFF, 8'hC0, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'hF0, 8'hFE, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic       req_type;
    logic       line_busy;
    logic [7:0] start_station;
    logic [7:0] end_station;
    logic [7:0] next_station;
    logic [2:0] run_state;
    logic [6:0] door_side;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       frame_is_clear;
  } frame_t;

  typedef struct packed {
    logic [7:0] start_station;
    logic [7:0] end_station;
    logic [7:0] next_station;
    logic [2:0] run_state;
    logic [6:0] door_side;
  } status_t;

  typedef struct packed {
    logic go;
    logic clear_sel;
  } seq_cmd_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [2:0]       src;
    logic [7:0]       konst;
    logic             add;
    logic             last;
    logic             clear;
    logic [UPC_W-1:0] target;
  } cw_t;

  function automatic cw_t emit_k(input logic [7:0] b, input logic add,
                                 input logic last, input logic clr);
    cw_t cw;
    cw       = '0;
    cw.op    = OP_EMIT;
    cw.src   = SRC_CONST;
    cw.konst = b;
    cw.add   = add;
    cw.last  = last;
    cw.clear = clr;
    return cw;
  endfunction

  function automatic cw_t emit_f(input logic [2:0] src, input logic add);
    cw_t cw;
    cw     = '0;
    cw.op  = OP_EMIT;
    cw.src = src;
    cw.add = add;
    return cw;
  endfunction

  // Step 0 dispatches; status frame at 1..15, clear frame at 16..33.
  function automatic cw_t ucode(input logic [UPC_W-1:0] upc);
    cw_t        cw;
    logic [4:0] k;
    cw    = '0;
    cw.op = OP_HALT;
    k     = 5'(upc - CLEAR_ENTRY);
    case (upc)
      6'd0: begin
        cw.op     = OP_BRANCH;
        cw.target = CLEAR_ENTRY;
      end
      6'd1:  cw = emit_k(8'hFF, 1'b0, 1'b0, 1'b0);
      6'd2:  cw = emit_k(8'hC0, 1'b1, 1'b0, 1'b0);
      6'd3:  cw = emit_k(8'h00, 1'b1, 1'b0, 1'b0);
      6'd4:  cw = emit_f(SRC_START, 1'b1);
      6'd5:  cw = emit_f(SRC_END, 1'b1);
      6'd6:  cw = emit_f(SRC_NEXT, 1'b1);
      6'd7:  cw = emit_f(SRC_B6, 1'b1);
      6'd8:  cw = emit_f(SRC_B7, 1'b1);
      6'd9:  cw = emit_k(8'h00, 1'b1, 1'b0, 1'b0);
      6'd10: cw = emit_k(8'h01, 1'b1, 1'b0, 1'b0);
      6'd11: cw = emit_k(8'h00, 1'b1, 1'b0, 1'b0);
      6'd12: cw = emit_k(8'h00, 1'b1, 1'b0, 1'b0);
      6'd13: cw = emit_k(8'h00, 1'b1, 1'b0, 1'b0);
      6'd14: cw = emit_f(SRC_SUM, 1'b0);
      6'd15: cw = emit_k(8'hFE, 1'b0, 1'b1, 1'b0);
      default: begin
        if (upc inside {[CLEAR_ENTRY:CLEAR_LAST]}) begin
          cw = emit_k(CLEAR_FRAME[k], 1'b0, upc == CLEAR_LAST, 1'b1);
        end
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

FILE: src/station_display_frame_emitter_unit.sv
// An emitting item starts the sequencer at its dispatch step, which branches
// to the first byte of the frame; bytes are registered on the output. A clear
// frame is dispatch + 18 bytes, a status frame dispatch + 15, one byte per
// step unless the output stalls; item_stall holds new items while busy.
// Reset (synchronous): idle_gap 20, repeat_count 2, status and counters zero.
// Top level of the station display frame emitter: config port, status state
// and repeat logic. Depends on sdfe_pkg and sdfe_seq.
`timescale 1ns / 1ps
`default_nettype none

module station_display_frame_emitter_unit (
  input  wire               clk,
  input  wire               rst,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [2:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire               item_valid,
  output logic              item_stall,
  input  sdfe_pkg::item_t   item,
  output logic              frame_valid,
  input  wire               frame_stall,
  output sdfe_pkg::frame_t  frame
);
  import sdfe_pkg::*;

  logic [15:0] idle_gap;
  logic [3:0]  repeat_count;
  status_t     status;
  status_t     status_next;
  logic [4:0]  repeats_left;
  logic [4:0]  repeats_left_next;
  logic [15:0] idle_ticks;
  logic [15:0] idle_ticks_next;

  seq_cmd_t    cmd;
  logic        seq_busy;
  logic        accept;
  logic        cfg_write;
  logic        diff;
  logic [4:0]  reload;
  logic [15:0] idle_inc;
  logic        rep_due;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign item_stall = seq_busy;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    case (paddr[2])
      CFG_REPEAT: prdata = {28'h0, repeat_count};
      default:    prdata = {16'h0, idle_gap};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_gap     <= 16'd20;
      repeat_count <= 4'd2;
    end else if (cfg_write) begin
      case (paddr[2])
        CFG_REPEAT: repeat_count <= pwdata[3:0];
        default:    idle_gap     <= pwdata[15:0];
      endcase
    end
  end

  assign diff     = item.start_station != status.start_station ||
                    item.end_station != status.end_station;
  assign reload   = {repeat_count, 1'b0} - 5'd1;
  assign idle_inc = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;
  assign rep_due  = idle_inc > idle_gap && repeats_left != 5'd0;

  always_comb begin
    cmd               = '0;
    status_next       = status;
    repeats_left_next = repeats_left;
    idle_ticks_next   = idle_ticks;
    if (accept) begin
      if (item.req_type == REQ_STATUS) begin
        cmd.go            = 1'b1;
        cmd.clear_sel     = diff || (5'd1 > {1'b0, repeat_count});
        repeats_left_next = diff ? reload : 5'd1;
        idle_ticks_next   = '0;
        status_next       = '{start_station: item.start_station,
                              end_station:   item.end_station,
                              next_station:  item.next_station,
                              run_state:     item.run_state,
                              door_side:     item.door_side};
      end else if (item.line_busy) begin
        idle_ticks_next = '0;
      end else if (rep_due) begin
        // repeat of the stored status; start/end match by construction
        cmd.go            = 1'b1;
        cmd.clear_sel     = repeats_left > {1'b0, repeat_count};
        repeats_left_next = repeats_left - 5'd1;
        idle_ticks_next   = '0;
      end else begin
        idle_ticks_next = idle_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status       <= '0;
      repeats_left <= '0;
      idle_ticks   <= '0;
    end else begin
      status       <= status_next;
      repeats_left <= repeats_left_next;
      idle_ticks   <= idle_ticks_next;
    end
  end

  sdfe_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .busy        (seq_busy),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame)
  );

`ifndef SYNTHESIS
  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.go |=> seq_busy)
    else $error("sequencer not busy after start");
  a_start_idle_clr: assert property (@(posedge clk) disable iff (rst)
    accept && item.req_type == REQ_STATUS |=> idle_ticks == 16'd0)
    else $error("idle count not cleared by status transaction");
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(status))
    else $error("stored status changed without a transaction");
`endif

endmodule

`default_nettype wire

FILE: src/sdfe_seq.sv
// Microcoded frame sequencer: step counter, control ROM from sdfe_pkg,
// byte mux, checksum accumulator and output register. Depends on sdfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdfe_seq (
  input  wire                clk,
  input  wire                rst,
  input  sdfe_pkg::seq_cmd_t cmd,
  input  sdfe_pkg::status_t  status,
  output logic               busy,
  output logic               frame_valid,
  input  wire                frame_stall,
  output sdfe_pkg::frame_t   frame
);
  import sdfe_pkg::*;

  logic             running;
  logic [UPC_W-1:0] upc;
  logic             clear_sel;
  logic [7:0]       acc;
  cw_t              cw;
  logic [7:0]       b6;
  logic [7:0]       b7;
  logic [7:0]       byte_sel;
  logic             slot_free;
  logic             emit;

  assign cw        = ucode(upc);
  assign slot_free = !frame_valid || !frame_stall;
  assign emit      = running && cw.op == OP_EMIT && slot_free;
  assign busy      = running;

  always_comb begin
    b6 = 8'h00;
    b7 = 8'h00;
    case (status.run_state)
      RUN_OPEN:     b7 = 8'h80 | {1'b0, status.door_side};
      RUN_CLOSE:    b7 = 8'h03;
      RUN_PRE_DOOR: b6 = {1'b0, status.door_side};
      default: ;
    endcase
  end

  always_comb begin
    case (cw.src)
      SRC_START: byte_sel = status.start_station;
      SRC_END:   byte_sel = status.end_station;
      SRC_NEXT:  byte_sel = status.next_station;
      SRC_B6:    byte_sel = b6;
      SRC_B7:    byte_sel = b7;
      SRC_SUM:   byte_sel = acc;
      default:   byte_sel = cw.konst;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      upc         <= '0;
      clear_sel   <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      if (cmd.go) begin
        running   <= 1'b1;
        upc       <= '0;
        clear_sel <= cmd.clear_sel;
      end else if (running) begin
        case (cw.op)
          OP_BRANCH: begin
            upc <= clear_sel ? cw.target : upc + UPC_W'(1);
          end
          OP_EMIT: begin
            if (slot_free) begin
              upc <= upc + UPC_W'(1);
              if (cw.last) begin
                running <= 1'b0;
              end
            end
          end
          default: running <= 1'b0;
        endcase
      end
      if (emit) begin
        frame_valid <= 1'b1;
      end else if (!frame_stall) begin
        frame_valid <= 1'b0;
      end
    end
  end

  // checksum and output payload
  always_ff @(posedge clk) begin
    if (running && cw.op == OP_BRANCH) begin
      acc <= 8'h00;
    end else if (emit && cw.add) begin
      acc <= acc + byte_sel;
    end
    if (emit) begin
      frame.frame_byte     <= byte_sel;
      frame.frame_last     <= cw.last;
      frame.frame_is_clear <= cw.clear;
    end
  end

`ifndef SYNTHESIS
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    emit && cw.last |=> !running || $past(cmd.go))
    else $error("sequencer kept running after last byte");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_stall |=> frame_valid)
    else $error("pending frame byte dropped");
  a_branch_first: assert property (@(posedge clk) disable iff (rst)
    cmd.go |=> running && upc == '0)
    else $error("sequencer did not start at dispatch step");
`endif

endmodule

`default_nettype wire
